// ===== hdl/trht_pkg.sv =====
// Shared types, sizes and codes of the text region hit table.
// Depends on nothing; imported by every module of the block.
package trht_pkg;

    localparam int MAX_REGIONS = 32;
    localparam int COORD_BITS  = 9;
    localparam int IDX_BITS    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_BITS    = $clog2(MAX_REGIONS + 1);

    localparam int OP_W     = 2;
    localparam int FCOORD_W = 9;
    localparam int FIDX_W   = 6;
    localparam int NUM_W    = 6;
    localparam int BOUND_W  = 10;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_FIND  = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t c0;
        coord_t r0;
        coord_t c1;
        coord_t r1;
    } span_t;

    typedef struct packed {
        opcode_t             op;
        logic [FCOORD_W-1:0] point_col;
        logic [FCOORD_W-1:0] point_row;
        logic [FCOORD_W-1:0] start_col;
        logic [FCOORD_W-1:0] start_row;
        logic [FCOORD_W-1:0] end_col;
        logic [FCOORD_W-1:0] end_row;
        logic [FIDX_W-1:0]   region_index;
    } req_t;

    typedef struct packed {
        logic [NUM_W-1:0]          region_number;
        logic signed [BOUND_W-1:0] bound_start_col;
        logic signed [BOUND_W-1:0] bound_start_row;
        logic signed [BOUND_W-1:0] bound_end_col;
        logic signed [BOUND_W-1:0] bound_end_row;
        status_t                   status;
    } res_t;

    typedef struct packed {
        logic    load;
        logic    clr_count;
        logic    append;
        logic    rd_en;
        logic    rd_sel_idx;
        logic    ptr_clr;
        logic    ptr_inc;
        logic    res_load;
        logic    res_entry;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    idx_ok;
        logic    ptr_at_count;
        logic    hit;
    } sts_t;

endpackage

// ===== hdl/text_region_hit_table_core.sv =====
// Top level of the text region hit table: stream ports, field packing,
// controller and datapath. Depends on trht_pkg, trht_ctrl, trht_datapath.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  s_axis_tdata, 64 bits
//   m_axis    out  m_axis_tvalid/m_axis_tready  m_axis_tdata, 48 bits
//
// One request at a time. Clear, add and read go from request accept through the
// dispatch state to the finish state; a find scans between the two, examining the
// stored regions one at a time through the single read port of the region memory,
// up to MAX_REGIONS of them, until the first hit.
// aresetn (synchronous) empties the table; stored entries need no clearing.
// A result waiting on m_axis_tready holds the next request's result back,
// but the next request is accepted meanwhile.
module text_region_hit_table_core import trht_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // opcode[1:0] point_col[10:2] point_row[19:11] start_col[28:20]
    // start_row[37:29] end_col[46:38] end_row[55:47] region_index[61:56]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // region_number[5:0] bound_start_col[15:6] bound_start_row[25:16]
    // bound_end_col[35:26] bound_end_row[45:36] status[47:46]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    req_t req_in;
    res_t res;
    cmd_t cmd;
    sts_t sts;

    assign req_in.op           = opcode_t'(s_axis_tdata[1:0]);
    assign req_in.point_col    = s_axis_tdata[10:2];
    assign req_in.point_row    = s_axis_tdata[19:11];
    assign req_in.start_col    = s_axis_tdata[28:20];
    assign req_in.start_row    = s_axis_tdata[37:29];
    assign req_in.end_col      = s_axis_tdata[46:38];
    assign req_in.end_row      = s_axis_tdata[55:47];
    assign req_in.region_index = s_axis_tdata[61:56];

    assign m_axis_tdata = {res.status, res.bound_end_row, res.bound_end_col,
                           res.bound_start_row, res.bound_start_col, res.region_number};

    trht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    trht_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_in  (req_in),
        .cmd     (cmd),
        .sts     (sts),
        .res     (res)
    );

endmodule

// ===== hdl/trht_datapath.sv =====
// Datapath of the text region hit table: request registers, region memory,
// scan pointer, region test and result register. Depends on trht_pkg.
module trht_datapath import trht_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  req_t req_in,
    input  cmd_t cmd,
    output sts_t sts,
    output res_t res
);

    span_t mem [MAX_REGIONS];

    req_t                req_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] ptr_reg;
    span_t               rd_data_reg;
    logic [IDX_BITS-1:0] pend_idx_reg;
    res_t                res_reg;

    logic [IDX_BITS-1:0] rd_addr;
    coord_t              pc;
    coord_t              pr;
    span_t               wr_span;

    function automatic logic span_holds(span_t s, coord_t c, coord_t r);
        logic on_one;
        on_one = (s.r0 == s.r1);
        if (on_one) begin
            return (r == s.r0) && (c >= s.c0) && (c < s.c1);
        end
        return ((r == s.r0) && (c >= s.c0)) || ((r == s.r1) && (c < s.c1)) ||
               ((r > s.r0) && (r < s.r1));
    endfunction

    function automatic logic signed [BOUND_W-1:0] bound_of(coord_t v);
        return BOUND_W'(v);
    endfunction

    assign pc         = COORD_BITS'(req_reg.point_col);
    assign pr         = COORD_BITS'(req_reg.point_row);
    assign wr_span.c0 = COORD_BITS'(req_reg.start_col);
    assign wr_span.r0 = COORD_BITS'(req_reg.start_row);
    assign wr_span.c1 = COORD_BITS'(req_reg.end_col);
    assign wr_span.r1 = COORD_BITS'(req_reg.end_row);

    assign rd_addr = cmd.rd_sel_idx ? IDX_BITS'(req_reg.region_index) : ptr_reg[IDX_BITS-1:0];

    assign sts.op           = req_reg.op;
    assign sts.full         = (count_reg == CNT_BITS'(MAX_REGIONS));
    assign sts.idx_ok       = (int'(req_reg.region_index) < int'(count_reg));
    assign sts.ptr_at_count = (ptr_reg == count_reg);
    assign sts.hit          = span_holds(rd_data_reg, pc, pr);

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            mem[count_reg[IDX_BITS-1:0]] <= wr_span;
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            pend_idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clr_count) begin
            count_reg <= '0;
        end else if (cmd.append) begin
            count_reg <= count_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req_in;
        end
        if (cmd.ptr_clr) begin
            ptr_reg <= '0;
        end else if (cmd.ptr_inc) begin
            ptr_reg <= ptr_reg + CNT_BITS'(1);
        end
        if (cmd.res_load) begin
            res_reg.status <= cmd.res_status;
            if (cmd.res_entry) begin
                res_reg.region_number   <= NUM_W'(pend_idx_reg) + NUM_W'(1);
                res_reg.bound_start_col <= bound_of(rd_data_reg.c0);
                res_reg.bound_start_row <= bound_of(rd_data_reg.r0);
                res_reg.bound_end_col   <= bound_of(rd_data_reg.c1);
                res_reg.bound_end_row   <= bound_of(rd_data_reg.r1);
            end else begin
                res_reg.region_number   <= '0;
                res_reg.bound_start_col <= '1;
                res_reg.bound_start_row <= '1;
                res_reg.bound_end_col   <= '1;
                res_reg.bound_end_row   <= '1;
            end
        end
    end

endmodule

// ===== hdl/trht_ctrl.sv =====
// Controller of the text region hit table: request handshake, operation
// sequencing, scan control and result handshake. Depends on trht_pkg.
module trht_ctrl import trht_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t  state_reg;
    logic    pend_reg;
    logic    entry_reg;
    status_t status_reg;
    logic    m_valid_reg;

    logic    out_free;
    logic    accept;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    always_comb begin
        cmd            = '0;
        cmd.res_status = status_reg;
        cmd.res_entry  = entry_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load = accept;
            end
            S_DISPATCH: begin
                unique case (sts.op)
                    OP_CLEAR: cmd.clr_count = 1'b1;
                    OP_ADD:   cmd.append    = !sts.full;
                    OP_FIND:  cmd.ptr_clr   = 1'b1;
                    OP_READ: begin
                        cmd.rd_en      = sts.idx_ok;
                        cmd.rd_sel_idx = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (!(pend_reg && sts.hit) && !sts.ptr_at_count) begin
                    cmd.rd_en   = 1'b1;
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_FINISH: begin
                cmd.res_load = out_free;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            entry_reg   <= 1'b0;
            status_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    entry_reg  <= 1'b0;
                    status_reg <= ST_OK;
                    pend_reg   <= 1'b0;
                    state_reg  <= S_FINISH;
                    unique case (sts.op)
                        OP_CLEAR: ;
                        OP_ADD: begin
                            if (sts.full) begin
                                status_reg <= ST_FULL;
                            end
                        end
                        OP_FIND: begin
                            state_reg <= S_SCAN;
                        end
                        OP_READ: begin
                            entry_reg <= sts.idx_ok;
                            if (!sts.idx_ok) begin
                                status_reg <= ST_RANGE;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    priority if (pend_reg && sts.hit) begin
                        entry_reg <= 1'b1;
                        state_reg <= S_FINISH;
                    end else if (sts.ptr_at_count) begin
                        state_reg <= S_FINISH;
                    end else begin
                        pend_reg <= 1'b1;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== hdl/trht_checker.sv =====
// Port-level checks of the text region hit table, bound to the top level.
// Depends on trht_pkg and text_region_hit_table_core.
module trht_checker import trht_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [NUM_W-1:0]    num;
    logic [STATUS_W-1:0] st;
    logic [4*BOUND_W-1:0] bounds;

    assign num    = m_axis_tdata[5:0];
    assign bounds = m_axis_tdata[45:6];
    assign st     = m_axis_tdata[47:46];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    a_miss_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (num == '0) |-> (bounds == '1))
        else $error("bounds not -1 without a region");

    a_err_num: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (st != ST_OK) |-> (num == '0))
        else $error("region number with error status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (st == ST_OK) || (st == ST_FULL) || (st == ST_RANGE))
        else $error("status code unknown");

endmodule

bind text_region_hit_table_core trht_checker u_trht_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
